// ===== sv/sli_pkg.sv =====
// Package with shared types and constants of the sorted list core.
package sli_pkg;

	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic proc;
		logic commit;
	} sli_cmd_t;

	typedef struct packed {
		logic run_needed;
		logic more;
		logic stop;
	} sli_sts_t;

endpackage

// ===== sv/sli_if.sv =====
// Handshake interfaces for the request and response channels.
interface sli_req_if;
	logic                              valid;
	logic                              ready;
	logic                              func;
	logic signed [sli_pkg::DATA_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface sli_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [sli_pkg::COUNT_W-1:0] count;

	modport source (output valid, output status, output count, input ready);
	modport sink (input valid, input status, input count, output ready);
endinterface

// ===== sv/sli_datapath.sv =====
// Datapath of the sorted list: entry memory, scan pointers, shift and result registers.
module sli_datapath #(
	parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sli_pkg::sli_cmd_t                 cmd,
	output sli_pkg::sli_sts_t                 sts,
	input  logic                              in_func,
	input  logic signed [sli_pkg::DATA_W-1:0] in_value,
	output logic [1:0]                        out_status,
	output logic [sli_pkg::COUNT_W-1:0]       out_count
);
	import sli_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [DATA_W-1:0] mem [CAPACITY];

	logic              func_q;
	logic [DATA_W-1:0] val_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rem_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW-1:0]     pos_q;
	logic              found_q;
	status_t           status_q;
	logic [DATA_W-1:0] rd_data_s1;
	logic [AW-1:0]     idx_s1;
	logic [1:0]        out_status_q;
	logic [COUNT_W-1:0] out_count_q;

	logic              is_full;
	logic              is_empty;
	logic [AW-1:0]     last_idx;
	logic              ins_ge;
	logic              rem_eq;
	logic              we;
	logic [AW-1:0]     wa;
	logic [DATA_W-1:0] wd;
	logic [CW-1:0]     count_nxt;

	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign last_idx = AW'(count_q - CW'(1));
	assign ins_ge   = ($signed(rd_data_s1) >= $signed(val_q));
	assign rem_eq   = (rd_data_s1 == val_q);

	always_comb begin
		sts.run_needed = !is_empty && !(in_func == FUNC_INSERT && is_full);
		sts.more       = (rem_q != '0);
		if (func_q == FUNC_INSERT) begin
			sts.stop = !ins_ge || (idx_s1 == '0);
		end else begin
			sts.stop = (idx_s1 == last_idx);
		end
	end

	always_comb begin
		we        = 1'b0;
		wa        = pos_q;
		wd        = val_q;
		count_nxt = count_q;
		if (cmd.commit) begin
			if (status_q == ST_OK && func_q == FUNC_INSERT) begin
				we        = 1'b1;
				wa        = pos_q;
				wd        = val_q;
				count_nxt = count_q + CW'(1);
			end else if (status_q == ST_OK) begin
				count_nxt = count_q - CW'(1);
			end
		end else if (cmd.proc) begin
			if (func_q == FUNC_INSERT) begin
				we = ins_ge;
				wa = idx_s1 + AW'(1);
				wd = rd_data_s1;
			end else begin
				we = found_q;
				wa = idx_s1 - AW'(1);
				wd = rd_data_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[rd_ptr_q];
			idx_s1     <= rd_ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_func;
			val_q    <= in_value;
			rem_q    <= count_q;
			found_q  <= 1'b0;
			pos_q    <= '0;
			rd_ptr_q <= (in_func == FUNC_INSERT) ? last_idx : '0;
			if (in_func == FUNC_INSERT) begin
				status_q <= is_full ? ST_FULL : ST_OK;
			end else begin
				status_q <= is_empty ? ST_EMPTY : ST_NOT_FOUND;
			end
		end else begin
			if (cmd.issue) begin
				rem_q    <= rem_q - CW'(1);
				rd_ptr_q <= (func_q == FUNC_INSERT) ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
			end
			if (cmd.proc) begin
				if (func_q == FUNC_INSERT) begin
					if (!ins_ge) begin
						pos_q <= idx_s1 + AW'(1);
					end else if (idx_s1 == '0) begin
						pos_q <= '0;
					end
				end else if (!found_q && rem_eq) begin
					found_q  <= 1'b1;
					status_q <= ST_OK;
				end
			end
		end
		if (cmd.commit) begin
			out_status_q <= status_q;
			out_count_q  <= COUNT_W'(count_nxt);
		end
	end

	assign out_status = out_status_q;
	assign out_count  = out_count_q;

endmodule

// ===== sv/sli_ctrl.sv =====
// Controller state machine of the sorted list: handshakes, scan sequencing and result valid.
module sli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sli_pkg::sli_cmd_t cmd,
	input  sli_pkg::sli_sts_t sts
);
	import sli_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   v_s1;
	logic   v_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		v_d     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.run_needed ? S_RUN : S_FIN;
				end
			end
			S_RUN: begin
				cmd.issue = sts.more;
				cmd.proc  = v_s1;
				v_d       = sts.more;
				if (v_s1 && sts.stop) begin
					state_d = S_FIN;
					v_d     = 1'b0;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= v_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/sorted_list_insert_remove_core.sv =====
// Top level of the sorted list core with insert and remove operations.
//
//  Channel | Dir | Fields          | Meaning
//  req     | in  | func, value     | insert in order, or remove first equal value
//  rsp     | out | status, count   | outcome code and number of stored values
//
// An insert scans down from the last value and shifts each value not below the new one
// up until its place is found; a remove scans the whole list and shifts the values after
// the first match down. The memory streams one entry per cycle while shifting. An insert
// into an empty or full list or a remove from an empty list skips the scan. Reset empties
// the list. A stalled response waits in its output register; the following item is still
// accepted and processed, but its result then waits and holds any further item at req.
module sorted_list_insert_remove_core #(
	parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sli_req_if.sink   req,
	sli_rsp_if.source rsp
);
	import sli_pkg::*;

	sli_cmd_t cmd;
	sli_sts_t sts;

	sli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sli_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_func   (req.func),
		.in_value  (req.value),
		.out_status(rsp.status),
		.out_count (rsp.count)
	);

endmodule

// ===== sv/sli_checker.sv =====
// Port checker of the sorted list core and its bind to the top level.
module sli_checker #(
	parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [1:0]                  rsp_status,
	input logic [sli_pkg::COUNT_W-1:0] rsp_count
);
	import sli_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Response valid dropped while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request accepted back to back.");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
		else $error("Empty status with a nonzero count.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_count == COUNT_W'(CAPACITY))
		else $error("Full status with a count other than the capacity.");

endmodule

bind sorted_list_insert_remove_core sli_checker #(
	.CAPACITY(CAPACITY)
) u_sli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_status(rsp.status),
	.rsp_count (rsp.count)
);
